/* sv/thtf_pkg.sv */
package thtf_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR         = 2'd0,
      ACT_SAMPLE        = 2'd1,
      ACT_QUERY_REGION  = 2'd2,
      ACT_QUERY_SECTION = 2'd3
   } action_type;

   localparam logic [7:0] THRESHOLD_RESET = 8'd128;

   typedef struct packed {
      logic       en;
      action_type action;
      logic [7:0] sample;
      logic [3:0] query_row;
      logic [3:0] query_col;
   } op_type;

   typedef struct packed {
      logic hole;
      logic map_done;
   } result_type;

endpackage

/* sv/terrain_hole_tile_flagger_top.sv */
// Throughput: one request per cycle while the response port is not stalled.
// Each request passes an input register, updates the tile maps, and lands in the
// response register; a stalled response holds the request in the input register and stalls the next one.
// Reset is synchronous and active high: it clears both maps, the raster position
// and the pipeline, and loads the hole threshold with 128.
module terrain_hole_tile_flagger_top
   import thtf_pkg::*;
#(
   parameter int TILES_PER_SIDE  = 16,
   parameter int TILE_SIZE       = 32,
   parameter int TILES_PER_GROUP = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_sample,
   input  logic [3:0] req_query_row,
   input  logic [3:0] req_query_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_hole,
   output logic       rsp_map_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_hole_threshold
);

   logic       s1_valid_ff, s1_valid_in;
   op_type     s1_op_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic [7:0] threshold_ff;
   logic       advance, accept;
   op_type     op_now;
   result_type result_now;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      op_now    = s1_op_ff;
      op_now.en = advance;
   end

   thtf_flag_maps #(
      .TILES_PER_SIDE (TILES_PER_SIDE),
      .TILE_SIZE      (TILE_SIZE),
      .TILES_PER_GROUP(TILES_PER_GROUP)
   ) u_maps (
      .clock     (clock),
      .reset     (reset),
      .op_in     (op_now),
      .threshold (threshold_ff),
      .result_out(result_now)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_hole_threshold;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff.en        <= 1'b1;
         s1_op_ff.action    <= action_type'(req_action);
         s1_op_ff.sample    <= req_sample;
         s1_op_ff.query_row <= req_query_row;
         s1_op_ff.query_col <= req_query_col;
      end
      if (advance) begin
         rsp_ff <= result_now;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hole     = rsp_ff.hole;
   assign rsp_map_done = rsp_ff.map_done;

`ifndef NO_ASSERTIONS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty input register");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed request did not reach the response register");

   a_no_hole_on_update: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_op_ff.action == ACT_CLEAR || s1_op_ff.action == ACT_SAMPLE)
         |=> !rsp_hole)
      else $error("hole flag set on a clear or sample response");

   a_clear_not_done: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_op_ff.action == ACT_CLEAR) |=> !rsp_map_done)
      else $error("map reported complete right after a clear");
`endif

endmodule

/* sv/thtf_flag_maps.sv */
module thtf_flag_maps
   import thtf_pkg::*;
#(
   parameter int TILES_PER_SIDE  = 16,
   parameter int TILE_SIZE       = 32,
   parameter int TILES_PER_GROUP = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  op_type     op_in,
   input  logic [7:0] threshold,
   output result_type result_out
);

   localparam int GROUPS = (TILES_PER_SIDE + TILES_PER_GROUP - 1) / TILES_PER_GROUP;
   localparam int TIDX_W = $clog2(TILES_PER_SIDE);
   localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int TCNT_W = $clog2(TILES_PER_SIDE + 1);
   localparam int TOFF_W = $clog2(TILE_SIZE);
   localparam int QEXT_W = ((TCNT_W > 4) ? TCNT_W : 4) + 1;

   logic [TCNT_W-1:0] row_tile_ff, row_tile_in;
   logic [TOFF_W-1:0] row_off_ff, row_off_in;
   logic [TCNT_W-1:0] col_tile_ff, col_tile_in;
   logic [TOFF_W-1:0] col_off_ff, col_off_in;
   logic              done_ff, done_in;

   logic [TILES_PER_SIDE-1:0][TILES_PER_SIDE-1:0] region_ff, region_in;
   logic [GROUPS-1:0][GROUPS-1:0]                 section_ff, section_in;

   logic [TILES_PER_SIDE-1:0] row_hit, col_hit;
   logic [GROUPS-1:0]         row_grp, col_grp;
   logic                      take_sample, mark_hole;

   logic [QEXT_W-1:0] qr_ext, qc_ext, region_flip, section_flip;
   logic              region_ok, section_ok;

   // A pixel on a tile boundary belongs to the tile it starts and the one it ends.
   always_comb begin
      row_hit = '0;
      col_hit = '0;
      row_grp = '0;
      col_grp = '0;
      for (int t = 0; t < TILES_PER_SIDE; t++) begin
         row_hit[t] = (row_tile_ff == TCNT_W'(t)) ||
                      ((row_off_ff == '0) && (row_tile_ff == TCNT_W'(t + 1)));
         col_hit[t] = (col_tile_ff == TCNT_W'(t)) ||
                      ((col_off_ff == '0) && (col_tile_ff == TCNT_W'(t + 1)));
      end
      for (int t = 0; t < TILES_PER_SIDE; t++) begin
         row_grp[GIDX_W'(t / TILES_PER_GROUP)] = row_grp[GIDX_W'(t / TILES_PER_GROUP)] |
                                                row_hit[t];
         col_grp[GIDX_W'(t / TILES_PER_GROUP)] = col_grp[GIDX_W'(t / TILES_PER_GROUP)] |
                                                col_hit[t];
      end
   end

   assign take_sample = op_in.en && (op_in.action == ACT_SAMPLE) && !done_ff;
   assign mark_hole   = take_sample && (op_in.sample < threshold);

   always_comb begin
      row_tile_in = row_tile_ff;
      row_off_in  = row_off_ff;
      col_tile_in = col_tile_ff;
      col_off_in  = col_off_ff;
      done_in     = done_ff;
      region_in   = region_ff;
      section_in  = section_ff;
      if (op_in.en && (op_in.action == ACT_CLEAR)) begin
         row_tile_in = '0;
         row_off_in  = '0;
         col_tile_in = '0;
         col_off_in  = '0;
         done_in     = 1'b0;
         region_in   = '0;
         section_in  = '0;
      end else if (take_sample) begin
         if (mark_hole) begin
            for (int r = 0; r < TILES_PER_SIDE; r++) begin
               for (int c = 0; c < TILES_PER_SIDE; c++) begin
                  region_in[r][c] = region_ff[r][c] | (row_hit[r] & col_hit[c]);
               end
            end
            for (int r = 0; r < GROUPS; r++) begin
               for (int c = 0; c < GROUPS; c++) begin
                  section_in[r][c] = section_ff[r][c] | (row_grp[r] & col_grp[c]);
               end
            end
         end
         if (col_tile_ff == TCNT_W'(TILES_PER_SIDE)) begin
            col_tile_in = '0;
            col_off_in  = '0;
            if (row_tile_ff == TCNT_W'(TILES_PER_SIDE)) begin
               done_in = 1'b1;
            end else if (row_off_ff == TOFF_W'(TILE_SIZE - 1)) begin
               row_off_in  = '0;
               row_tile_in = row_tile_ff + 1'b1;
            end else begin
               row_off_in = row_off_ff + 1'b1;
            end
         end else if (col_off_ff == TOFF_W'(TILE_SIZE - 1)) begin
            col_off_in  = '0;
            col_tile_in = col_tile_ff + 1'b1;
         end else begin
            col_off_in = col_off_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_tile_ff <= '0;
         row_off_ff  <= '0;
         col_tile_ff <= '0;
         col_off_ff  <= '0;
         done_ff     <= 1'b0;
         region_ff   <= '0;
         section_ff  <= '0;
      end else begin
         row_tile_ff <= row_tile_in;
         row_off_ff  <= row_off_in;
         col_tile_ff <= col_tile_in;
         col_off_ff  <= col_off_in;
         done_ff     <= done_in;
         region_ff   <= region_in;
         section_ff  <= section_in;
      end
   end

   // Stored rows run bottom up, so queries flip the row index.
   assign qr_ext       = QEXT_W'(op_in.query_row);
   assign qc_ext       = QEXT_W'(op_in.query_col);
   assign region_ok    = (qr_ext < QEXT_W'(TILES_PER_SIDE)) && (qc_ext < QEXT_W'(TILES_PER_SIDE));
   assign section_ok   = (qr_ext < QEXT_W'(GROUPS)) && (qc_ext < QEXT_W'(GROUPS));
   assign region_flip  = QEXT_W'(TILES_PER_SIDE - 1) - qr_ext;
   assign section_flip = QEXT_W'(GROUPS - 1) - qr_ext;

   always_comb begin
      result_out.map_done = done_in;
      unique case (op_in.action)
         ACT_QUERY_REGION: begin
            result_out.hole = region_ok &&
               region_ff[region_flip[TIDX_W-1:0]][qc_ext[TIDX_W-1:0]];
         end
         ACT_QUERY_SECTION: begin
            result_out.hole = section_ok &&
               section_ff[section_flip[GIDX_W-1:0]][qc_ext[GIDX_W-1:0]];
         end
         default: begin
            result_out.hole = 1'b0;
         end
      endcase
   end

endmodule
